// ----- hdl/cts_pkg.sv -----
// Shared types, token codes and keyword table for the C token scanner.
package cts_pkg;

  localparam int PosBitsDefault = 24;
  localparam int FieldW         = 24;
  localparam int PrefixChars    = 8;
  localparam int NumKeywords    = 11;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } cts_in_t;

  typedef struct packed {
    logic [6:0]        token_kind;
    logic [FieldW-1:0] start_offset;
    logic [FieldW-1:0] lexeme_length;
    logic [FieldW-1:0] line_no;
    logic              last_in_run;
  } cts_out_t;

  // Up to two tokens produced by one input beat.
  typedef struct packed {
    logic [1:0] count;
    cts_out_t   res0;
    cts_out_t   res1;
  } cts_res_t;

  localparam logic [6:0] K_ERROR    = 7'd0;
  localparam logic [6:0] K_EOF      = 7'd1;
  localparam logic [6:0] K_INT      = 7'd2;
  localparam logic [6:0] K_LONG     = 7'd3;
  localparam logic [6:0] K_LLONG    = 7'd4;
  localparam logic [6:0] K_UINT     = 7'd5;
  localparam logic [6:0] K_ULONG    = 7'd6;
  localparam logic [6:0] K_ULLONG   = 7'd7;
  localparam logic [6:0] K_FLOAT    = 7'd8;
  localparam logic [6:0] K_DOUBLE   = 7'd9;
  localparam logic [6:0] K_LDOUBLE  = 7'd10;
  localparam logic [6:0] K_CHARLIT  = 7'd11;
  localparam logic [6:0] K_IDENT    = 7'd12;
  localparam logic [6:0] K_KW_BASE  = 7'd13;
  localparam logic [6:0] K_LPAREN   = 7'd24;
  localparam logic [6:0] K_RPAREN   = 7'd25;
  localparam logic [6:0] K_LCURLY   = 7'd26;
  localparam logic [6:0] K_RCURLY   = 7'd27;
  localparam logic [6:0] K_SEMI     = 7'd28;
  localparam logic [6:0] K_MINUS    = 7'd29;
  localparam logic [6:0] K_MINUS_EQ = 7'd30;
  localparam logic [6:0] K_DEC      = 7'd31;
  localparam logic [6:0] K_TILDE    = 7'd32;
  localparam logic [6:0] K_BANG     = 7'd33;
  localparam logic [6:0] K_NE       = 7'd34;
  localparam logic [6:0] K_PLUS     = 7'd35;
  localparam logic [6:0] K_PLUS_EQ  = 7'd36;
  localparam logic [6:0] K_INC      = 7'd37;
  localparam logic [6:0] K_STAR     = 7'd38;
  localparam logic [6:0] K_TIMES_EQ = 7'd39;
  localparam logic [6:0] K_SLASH    = 7'd40;
  localparam logic [6:0] K_DIV_EQ   = 7'd41;
  localparam logic [6:0] K_AMP      = 7'd42;
  localparam logic [6:0] K_LAND     = 7'd43;
  localparam logic [6:0] K_AND_EQ   = 7'd44;
  localparam logic [6:0] K_PIPE     = 7'd45;
  localparam logic [6:0] K_LOR      = 7'd46;
  localparam logic [6:0] K_OR_EQ    = 7'd47;
  localparam logic [6:0] K_LT       = 7'd48;
  localparam logic [6:0] K_LE       = 7'd49;
  localparam logic [6:0] K_SHL      = 7'd50;
  localparam logic [6:0] K_SHL_EQ   = 7'd51;
  localparam logic [6:0] K_GT       = 7'd52;
  localparam logic [6:0] K_GE       = 7'd53;
  localparam logic [6:0] K_SHR      = 7'd54;
  localparam logic [6:0] K_SHR_EQ   = 7'd55;
  localparam logic [6:0] K_ASSIGN   = 7'd56;
  localparam logic [6:0] K_EQEQ     = 7'd57;
  localparam logic [6:0] K_MOD      = 7'd58;
  localparam logic [6:0] K_MOD_EQ   = 7'd59;
  localparam logic [6:0] K_XOR      = 7'd60;
  localparam logic [6:0] K_XOR_EQ   = 7'd61;
  localparam logic [6:0] K_COMMA    = 7'd62;
  localparam logic [6:0] K_QUEST    = 7'd63;
  localparam logic [6:0] K_COLON    = 7'd64;

  // Keyword text, first character in the low byte, zero padded.
  function automatic logic [63:0] kw_word(input logic [3:0] k);
    logic [63:0] w;
    w = '0;
    case (k)
      4'd0:    w = 64'("rahc");
      4'd1:    w = 64'("elbuod");
      4'd2:    w = 64'("esle");
      4'd3:    w = 64'("taolf");
      4'd4:    w = 64'("fi");
      4'd5:    w = 64'("tni");
      4'd6:    w = 64'("gnol");
      4'd7:    w = 64'("nruter");
      4'd8:    w = 64'("trohs");
      4'd9:    w = 64'("dengis");
      4'd10:   w = 64'("dengisnu");
      default: w = '1;
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/cts_scan.sv -----
// Scanner state and the per-byte token logic.
module cts_scan import cts_pkg::*; #(
  parameter int POSITION_BITS = PosBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  cts_in_t           in_i,
  input  logic              cfg_we_i,
  input  logic [FieldW-1:0] cfg_wdata_i,
  output cts_res_t          res_o
);

  localparam int PW = (POSITION_BITS < FieldW) ? POSITION_BITS : FieldW;
  localparam logic [PW-1:0] PosLim = {PW{1'b1}};

  typedef enum logic [13:0] {
    M_IDLE   = 14'b00000000000001,
    M_IDENT  = 14'b00000000000010,
    M_DIGITS = 14'b00000000000100,
    M_FRAC   = 14'b00000000001000,
    M_SUF_U  = 14'b00000000010000,
    M_SUF_UL = 14'b00000000100000,
    M_SUF_L  = 14'b00000001000000,
    M_SUF_LL = 14'b00000010000000,
    M_OP     = 14'b00000100000000,
    M_CHAR1  = 14'b00001000000000,
    M_CHAR2  = 14'b00010000000000,
    M_LINEC  = 14'b00100000000000,
    M_BLOCK  = 14'b01000000000000,
    M_BSTAR  = 14'b10000000000000
  } mode_e;

  typedef enum logic [1:0] {
    ACT_FLUSH = 2'd0,
    ACT_KEEP  = 2'd1,
    ACT_DONE  = 2'd2
  } act_e;

  mode_e             mode_q, mode_d;
  logic [6:0]        pend_q, pend_d;
  logic [63:0]       prefix_q, prefix_d;
  logic [PW-1:0]     start_q, start_d;
  logic [PW-1:0]     len_q, len_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [FieldW-1:0] line_q, line_d;
  logic [FieldW-1:0] first_q;

  function automatic logic digit_chr(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic word_chr(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
  endfunction

  function automatic logic [PW-1:0] sat_pos(input logic [PW-1:0] v);
    return (v == PosLim) ? v : v + 1'b1;
  endfunction

  function automatic logic [FieldW-1:0] sat_line(input logic [FieldW-1:0] v);
    return (v == {FieldW{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Second character of a two or three character operator.
  function automatic logic [6:0] op_next(input logic [6:0] k, input logic [7:0] b);
    logic [6:0] r;
    r = K_ERROR;
    case (k)
      K_MINUS:  r = (b == "=") ? K_MINUS_EQ : ((b == "-") ? K_DEC : K_ERROR);
      K_BANG:   r = (b == "=") ? K_NE : K_ERROR;
      K_PLUS:   r = (b == "=") ? K_PLUS_EQ : ((b == "+") ? K_INC : K_ERROR);
      K_STAR:   r = (b == "=") ? K_TIMES_EQ : K_ERROR;
      K_SLASH:  r = (b == "=") ? K_DIV_EQ : K_ERROR;
      K_AMP:    r = (b == "&") ? K_LAND : ((b == "=") ? K_AND_EQ : K_ERROR);
      K_PIPE:   r = (b == "|") ? K_LOR : ((b == "=") ? K_OR_EQ : K_ERROR);
      K_LT:     r = (b == "=") ? K_LE : ((b == "<") ? K_SHL : K_ERROR);
      K_SHL:    r = (b == "=") ? K_SHL_EQ : K_ERROR;
      K_GT:     r = (b == "=") ? K_GE : ((b == ">") ? K_SHR : K_ERROR);
      K_SHR:    r = (b == "=") ? K_SHR_EQ : K_ERROR;
      K_ASSIGN: r = (b == "=") ? K_EQEQ : K_ERROR;
      K_MOD:    r = (b == "=") ? K_MOD_EQ : K_ERROR;
      K_XOR:    r = (b == "=") ? K_XOR_EQ : K_ERROR;
      default:  r = K_ERROR;
    endcase
    return r;
  endfunction

  function automatic cts_out_t mk(input logic [6:0] k, input logic [PW-1:0] s,
                                  input logic [PW-1:0] l, input logic [FieldW-1:0] ln);
    cts_out_t o;
    o.token_kind    = k;
    o.start_offset  = FieldW'(s);
    o.lexeme_length = FieldW'(l);
    o.line_no       = ln;
    o.last_in_run   = 1'b0;
    return o;
  endfunction

  logic [7:0] b, lc;
  logic [6:0] word_k, flush_k, st_k, nk;
  logic       st_single, st_ws, st_nl, do_start;
  act_e       act;
  logic [1:0] cnt;
  cts_out_t   r0, r1;

  assign b  = in_i.source_byte;
  assign lc = b | 8'h20;

  // Identifier or keyword.
  always_comb begin
    word_k = K_IDENT;
    for (int k = 0; k < NumKeywords; k++) begin
      if ((len_q <= PW'(PrefixChars)) && (prefix_q == kw_word(4'(k)))) begin
        word_k = K_KW_BASE + 7'(k);
      end
    end
  end

  always_comb begin
    if (mode_q == M_IDENT) begin
      flush_k = word_k;
    end else if ((mode_q == M_CHAR1) || (mode_q == M_CHAR2) || (mode_q == M_LINEC) ||
                 (mode_q == M_BLOCK) || (mode_q == M_BSTAR)) begin
      flush_k = K_ERROR;
    end else begin
      flush_k = pend_q;
    end
  end

  // Decode of a byte seen between tokens.
  always_comb begin
    st_k      = K_ERROR;
    st_single = 1'b0;
    st_ws     = 1'b0;
    st_nl     = 1'b0;
    case (b)
      " ", 8'h09, 8'h0d: st_ws = 1'b1;
      8'h0a:   st_nl = 1'b1;
      "(":     begin st_k = K_LPAREN; st_single = 1'b1; end
      ")":     begin st_k = K_RPAREN; st_single = 1'b1; end
      "{":     begin st_k = K_LCURLY; st_single = 1'b1; end
      "}":     begin st_k = K_RCURLY; st_single = 1'b1; end
      ";":     begin st_k = K_SEMI;   st_single = 1'b1; end
      "~":     begin st_k = K_TILDE;  st_single = 1'b1; end
      ",":     begin st_k = K_COMMA;  st_single = 1'b1; end
      "?":     begin st_k = K_QUEST;  st_single = 1'b1; end
      ":":     begin st_k = K_COLON;  st_single = 1'b1; end
      "-":     st_k = K_MINUS;
      "!":     st_k = K_BANG;
      "+":     st_k = K_PLUS;
      "*":     st_k = K_STAR;
      "/":     st_k = K_SLASH;
      "&":     st_k = K_AMP;
      "|":     st_k = K_PIPE;
      "<":     st_k = K_LT;
      ">":     st_k = K_GT;
      "=":     st_k = K_ASSIGN;
      "%":     st_k = K_MOD;
      "^":     st_k = K_XOR;
      default: st_k = K_ERROR;
    endcase
  end

  assign nk = op_next(pend_q, b);

  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    prefix_d = prefix_q;
    start_d  = start_q;
    len_d    = len_q;
    pos_d    = pos_q;
    line_d   = line_q;
    cnt      = 2'd0;
    r0       = '0;
    r1       = '0;
    do_start = 1'b0;
    act      = ACT_KEEP;
    if (accept_i) begin
      if (in_i.end_of_input) begin
        // Flush whatever is open but a line comment, then EOF; rearm for a new stream.
        if ((mode_q != M_IDLE) && (mode_q != M_LINEC)) begin
          r0  = mk(flush_k, start_q, len_q, line_q);
          cnt = 2'd1;
        end
        if (cnt == 2'd0) r0 = mk(K_EOF, pos_q, '0, line_q);
        else             r1 = mk(K_EOF, pos_q, '0, line_q);
        cnt      = cnt + 2'd1;
        mode_d   = M_IDLE;
        pend_d   = K_ERROR;
        prefix_d = '0;
        start_d  = '0;
        len_d    = '0;
        pos_d    = '0;
        line_d   = first_q;
      end else begin
        if (mode_q == M_IDLE) begin
          do_start = 1'b1;
        end else begin
          unique case (mode_q)
            M_IDENT: begin
              if (!(word_chr(b) || digit_chr(b))) begin
                act = ACT_FLUSH;
              end else begin
                for (int i = 0; i < PrefixChars; i++) begin
                  if (len_q == PW'(i)) prefix_d[8*i +: 8] = b;
                end
              end
            end
            M_DIGITS: begin
              if (digit_chr(b)) act = ACT_KEEP;
              else if (b == ".") begin mode_d = M_FRAC; pend_d = K_DOUBLE; end
              else if (lc == "u") begin mode_d = M_SUF_U; pend_d = K_UINT; end
              else if (lc == "l") begin mode_d = M_SUF_L; pend_d = K_LONG; end
              else act = ACT_FLUSH;
            end
            M_FRAC: begin
              if (digit_chr(b)) act = ACT_KEEP;
              else if (lc == "f") begin pend_d = K_FLOAT; act = ACT_DONE; end
              else if (lc == "l") begin pend_d = K_LDOUBLE; act = ACT_DONE; end
              else act = ACT_FLUSH;
            end
            M_SUF_U: begin
              if (lc == "l") begin mode_d = M_SUF_UL; pend_d = K_ULONG; end
              else act = ACT_FLUSH;
            end
            M_SUF_UL: begin
              if (lc == "l") begin pend_d = K_ULLONG; act = ACT_DONE; end
              else act = ACT_FLUSH;
            end
            M_SUF_L: begin
              if (lc == "u") begin pend_d = K_ULONG; act = ACT_DONE; end
              else if (lc == "l") begin mode_d = M_SUF_LL; pend_d = K_LLONG; end
              else act = ACT_FLUSH;
            end
            M_SUF_LL: begin
              if (lc == "u") begin pend_d = K_ULLONG; act = ACT_DONE; end
              else act = ACT_FLUSH;
            end
            M_OP: begin
              if ((pend_q == K_SLASH) && (b == "*")) mode_d = M_BLOCK;
              else if ((pend_q == K_SLASH) && (b == "/")) mode_d = M_LINEC;
              else if (nk == K_ERROR) act = ACT_FLUSH;
              else begin
                pend_d = nk;
                act    = ((nk == K_SHL) || (nk == K_SHR)) ? ACT_KEEP : ACT_DONE;
              end
            end
            M_CHAR1: mode_d = M_CHAR2;
            M_CHAR2: begin
              pend_d = (b == 8'h27) ? K_CHARLIT : K_ERROR;
              act    = ACT_DONE;
            end
            M_LINEC: begin
              if (b == 8'h0a) begin line_d = sat_line(line_q); mode_d = M_IDLE; end
            end
            M_BLOCK: begin
              if (b == "*") mode_d = M_BSTAR;
              else if (b == 8'h0a) line_d = sat_line(line_q);
            end
            M_BSTAR: begin
              if (b == "/") mode_d = M_IDLE;
              else if (b == 8'h0a) begin line_d = sat_line(line_q); mode_d = M_BLOCK; end
              else if (b != "*") mode_d = M_BLOCK;
            end
            default: begin
              mode_d = M_IDLE;
              act    = ACT_FLUSH;
            end
          endcase
          if (act == ACT_FLUSH) begin
            r0       = mk(flush_k, start_q, len_q, line_q);
            cnt      = 2'd1;
            mode_d   = M_IDLE;
            do_start = 1'b1;
          end else begin
            len_d = sat_pos(len_q);
            if (act == ACT_DONE) begin
              r0     = mk(pend_d, start_q, len_d, line_q);
              cnt    = 2'd1;
              mode_d = M_IDLE;
            end
          end
        end
        if (do_start) begin
          if (st_nl) begin
            line_d = sat_line(line_q);
          end else if (!st_ws) begin
            start_d = pos_q;
            len_d   = PW'(1);
            if (st_single || ((st_k == K_ERROR) && !digit_chr(b) && !word_chr(b) &&
                              (b != 8'h27))) begin
              if (cnt == 2'd0) r0 = mk(st_k, pos_q, PW'(1), line_q);
              else             r1 = mk(st_k, pos_q, PW'(1), line_q);
              cnt = cnt + 2'd1;
            end else if (st_k != K_ERROR) begin
              mode_d = M_OP;
              pend_d = st_k;
            end else if (digit_chr(b)) begin
              mode_d = M_DIGITS;
              pend_d = K_INT;
            end else if (word_chr(b)) begin
              mode_d   = M_IDENT;
              pend_d   = K_IDENT;
              prefix_d = 64'(b);
            end else begin
              mode_d = M_CHAR1;
              pend_d = K_CHARLIT;
            end
          end
        end
        pos_d = sat_pos(pos_q);
      end
    end else if (cfg_we_i && (pos_q == '0) && (mode_q == M_IDLE)) begin
      line_d = cfg_wdata_i;
    end
    if (cnt == 2'd1) r0.last_in_run = 1'b1;
    if (cnt == 2'd2) r1.last_in_run = 1'b1;
  end

  assign res_o.count = cnt;
  assign res_o.res0  = r0;
  assign res_o.res1  = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      pend_q   <= K_ERROR;
      prefix_q <= '0;
      start_q  <= '0;
      len_q    <= '0;
      pos_q    <= '0;
      line_q   <= FieldW'(1);
      first_q  <= FieldW'(1);
    end else begin
      mode_q   <= mode_d;
      pend_q   <= pend_d;
      prefix_q <= prefix_d;
      start_q  <= start_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      if (cfg_we_i) first_q <= cfg_wdata_i;
    end
  end

endmodule

// ----- hdl/cts_queue.sv -----
// Three-entry token queue that takes up to two tokens per cycle.
module cts_queue import cts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cts_res_t push_i,
  output logic     room_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cts_out_t out_data_o
);

  cts_out_t   ent_q [3];
  cts_out_t   ent_d [3];
  logic [1:0] cnt_q, cnt_d, base;
  logic       pop;

  assign pop         = (cnt_q != 2'd0) && out_ready_i;
  assign base        = cnt_q - {1'b0, pop};
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = ent_q[0];
  // Take a beat only when both of its possible tokens fit.
  assign room_o      = (cnt_q <= 2'd1);

  always_comb begin
    ent_d[0] = pop ? ent_q[1] : ent_q[0];
    ent_d[1] = pop ? ent_q[2] : ent_q[1];
    ent_d[2] = ent_q[2];
    for (int i = 0; i < 3; i++) begin
      if ((push_i.count != 2'd0) && (base == 2'(i))) ent_d[i] = push_i.res0;
      if ((push_i.count == 2'd2) && (base + 2'd1 == 2'(i))) ent_d[i] = push_i.res1;
    end
    cnt_d = base + push_i.count;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) ent_q[i] <= ent_d[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hdl/c_token_scanner.sv -----
// Top level of the streaming C-subset token scanner.
//
// The scanner takes one source byte per beat and returns tokens (kind,
// start offset, length, line) with maximal munch and one byte of lookahead:
// a token whose end is only visible from the following byte is returned on
// that byte, along with any single-byte token the byte completes, so a beat
// yields zero, one or two tokens; last_in_run marks the final token of a
// beat. A beat with end_of_input set flushes the open token, returns EOF and
// restarts position and line counting for the next stream. Throughput is one
// byte per clock while the queue has room; a byte is taken whenever the
// three-entry result queue holds at most one token, so a beat that yields
// two tokens stalls the input when the consumer drains one token a cycle.
// Each byte is decoded by logic between the scanner state registers and the
// queue registers that drive the output. first_line_number is written by the
// user through cfg_we_i/cfg_wdata_i only while idle, not enforced by the block;
// a write also reloads the line counter if no byte of this stream was taken.
module c_token_scanner import cts_pkg::*; #(
  parameter int POSITION_BITS = PosBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cts_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cts_out_t          out_data_o,
  input  logic              cfg_we_i,
  input  logic [FieldW-1:0] cfg_wdata_i
);

  cts_res_t res;
  logic     accept;

  // A beat moves when the queue has room for both possible tokens.
  assign accept = in_valid_i && in_ready_o;

  cts_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_i       (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_o      (res)
  );

  cts_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res),
    .room_o     (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
